// ===== src/stu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the string to unsigned parser: shared constants, the queue token type
// and the character classification function. Used by every module of the block.
package stu_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int BASE_W          = 5;
  localparam int DIGIT_W         = 5;
  localparam int CNT_W           = 8;
  localparam int CHAR_W          = 8;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [BASE_W-1:0]  BASE_AUTO  = 5'd0;
  localparam logic [BASE_W-1:0]  BASE_OCT   = 5'd8;
  localparam logic [BASE_W-1:0]  BASE_DEC   = 5'd10;
  localparam logic [BASE_W-1:0]  BASE_HEX   = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 8'hFF;
  localparam logic [CNT_W-1:0]   CNT_ONE    = 8'd1;
  localparam logic [CNT_W-1:0]   CNT_TWO    = 8'd2;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_LA    = 8'h61;
  localparam logic [CHAR_W-1:0]  CHAR_LF    = 8'h66;
  localparam logic [CHAR_W-1:0]  CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_UF    = 8'h46;
  localparam logic [CHAR_W-1:0]  CHAR_LX    = 8'h78;
  localparam logic [CHAR_W-1:0]  CASE_BIT   = 8'h20;

  typedef enum logic [0:0] {
    REG_NUMBER_BASE = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic               first;
    logic               is_zero;
    logic               is_x;
    logic [DIGIT_W-1:0] digit;
    logic [BASE_W-1:0]  base;
  } tok_t;

  function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    begin
      d = DIGIT_NONE;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = DIGIT_W'(c - CHAR_ZERO);
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        d = DIGIT_W'(c - CHAR_LA + 8'd10);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        d = DIGIT_W'(c - CHAR_UA + 8'd10);
      end
      return d;
    end
  endfunction

endpackage

// ===== src/stu_front.sv =====
`timescale 1ns / 1ps
// Front end of the parser: accepts input items, classifies each character and
// pushes a token into the queue. Depends on stu_pkg.
module stu_front import stu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic              in_first,
  input  logic [BASE_W-1:0] number_base,
  input  logic              q_full,
  output logic              q_push,
  output tok_t              q_data
);

  logic accept;

  assign full   = q_full;
  assign accept = push & ~q_full;
  assign q_push = accept;

  always_comb begin
    q_data.first   = in_first;
    q_data.is_zero = (in_ch == CHAR_ZERO);
    q_data.is_x    = ((in_ch | CASE_BIT) == CHAR_LX);
    q_data.digit   = hex_value(in_ch);
    q_data.base    = number_base;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (q_data.is_zero ? (q_data.digit == '0) : 1'b1))
    else $error("zero character not classified as digit zero");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(q_data.is_x && q_data.digit != DIGIT_NONE))
    else $error("x character classified as a digit");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into a full queue");

endmodule

// ===== src/stu_queue.sv =====
`timescale 1ns / 1ps
// Short token queue between the front and back ends of the parser.
// Depends on stu_pkg for the token type and depth.
module stu_queue import stu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  tok_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output tok_t q_rdata,
  output logic q_empty
);

  tok_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_rdata = mem_r[rd_ptr_r];
  assign do_push = q_push & ~q_full;
  assign do_pop  = q_pop & ~q_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

// ===== src/stu_back.sv =====
`timescale 1ns / 1ps
// Back end of the parser: runs the prefix and digit state machine on queued tokens
// and holds the result item. Depends on stu_pkg.
module stu_back import stu_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tok_t                   q_rdata,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [CNT_W-1:0]       out_end_offset
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_ZERO   = 4'b0010,
    PH_ZERO_X = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic                     res_valid_r, res_valid_nxt;
  logic [VALUE_WIDTH-1:0]   res_value_r, res_value_nxt;
  logic [CNT_W-1:0]         res_off_r, res_off_nxt;

  logic                     consume;
  logic                     take;
  logic                     hold;
  logic [VALUE_WIDTH-1:0]   acc_in;
  logic [CNT_W-1:0]         cnt_in;
  logic [BASE_W-1:0]        base_eff;
  logic [VALUE_WIDTH+BASE_W-1:0] prod;
  logic [VALUE_WIDTH-1:0]   mac;
  logic                     emit;
  logic [VALUE_WIDTH-1:0]   emit_val;
  logic [CNT_W-1:0]         emit_cnt;

  assign consume = ~q_empty & (~res_valid_r | pop);
  assign q_pop   = consume;
  assign empty   = ~res_valid_r;
  assign out_value      = res_value_r;
  assign out_end_offset = res_off_r;

  always_comb begin
    take     = 1'b0;
    hold     = 1'b0;
    acc_in   = acc_r;
    cnt_in   = cnt_r;
    base_eff = base_r;
    if (consume) begin
      if (q_rdata.first) begin
        acc_in   = '0;
        cnt_in   = '0;
        base_eff = q_rdata.base;
        if (q_rdata.is_zero && (q_rdata.base == BASE_AUTO || q_rdata.base == BASE_HEX)) begin
          hold = 1'b1;
        end else begin
          if (q_rdata.base == BASE_AUTO) begin
            base_eff = BASE_DEC;
          end
          take = 1'b1;
        end
      end else begin
        unique case (phase_r)
          PH_ZERO: begin
            if (q_rdata.is_x) begin
              hold = 1'b1;
            end else begin
              if (base_r == BASE_AUTO) begin
                base_eff = BASE_OCT;
              end
              cnt_in = CNT_ONE;
              take   = 1'b1;
            end
          end
          PH_ZERO_X: begin
            if (q_rdata.digit != DIGIT_NONE) begin
              base_eff = BASE_HEX;
              cnt_in   = CNT_TWO;
              take     = 1'b1;
            end else begin
              hold = 1'b1;
            end
          end
          PH_DIGITS: begin
            take = 1'b1;
          end
          default: begin
            hold = 1'b0;
          end
        endcase
      end
    end
  end

  assign prod = (VALUE_WIDTH+BASE_W)'(acc_in) * (VALUE_WIDTH+BASE_W)'(base_eff);
  assign mac  = prod[VALUE_WIDTH-1:0] + VALUE_WIDTH'(q_rdata.digit);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    emit      = 1'b0;
    emit_val  = acc_r;
    emit_cnt  = cnt_r;
    if (take) begin
      base_nxt = base_eff;
      if (q_rdata.digit >= base_eff) begin
        emit      = 1'b1;
        emit_val  = acc_in;
        emit_cnt  = cnt_in;
        acc_nxt   = acc_in;
        cnt_nxt   = cnt_in;
        phase_nxt = PH_IDLE;
      end else begin
        acc_nxt   = mac;
        cnt_nxt   = (cnt_in == CNT_MAX) ? cnt_in : cnt_in + 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end else if (hold) begin
      if (q_rdata.first) begin
        acc_nxt   = '0;
        cnt_nxt   = '0;
        base_nxt  = q_rdata.base;
        phase_nxt = PH_ZERO;
      end else if (phase_r == PH_ZERO) begin
        if (base_r == BASE_AUTO) begin
          phase_nxt = PH_ZERO_X;
        end else begin
          cnt_nxt   = CNT_TWO;
          phase_nxt = PH_DIGITS;
        end
      end else begin
        emit      = 1'b1;
        emit_val  = '0;
        emit_cnt  = CNT_ONE;
        base_nxt  = BASE_OCT;
        acc_nxt   = '0;
        cnt_nxt   = CNT_ONE;
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    res_value_nxt = res_value_r;
    res_off_nxt   = res_off_r;
    if (emit) begin
      res_valid_nxt = 1'b1;
      res_value_nxt = emit_val;
      res_off_nxt   = emit_cnt;
    end else if (pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      base_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      base_r      <= base_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_value_r <= res_value_nxt;
    res_off_r   <= res_off_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(consume))
    else $error("result item appeared without a consumed token");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ZERO_X) |-> (base_r == BASE_AUTO && acc_r == '0))
    else $error("prefix phase entered outside automatic base");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ZERO) |-> (acc_r == '0 && cnt_r == '0))
    else $error("leading zero phase with nonzero accumulator or count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIGITS) |-> (cnt_r != '0))
    else $error("digit phase with zero count");

endmodule

// ===== src/string_to_unsigned_parser.sv =====
`timescale 1ns / 1ps
// Top level of the string to unsigned parser: configuration register, front end,
// token queue and back end. Depends on stu_pkg, stu_front, stu_queue and stu_back.
//
//   Channel   Handshake              Payload
//   input     push / full            in_ch[7:0], in_first
//   result    pop / empty            out_value[VALUE_WIDTH-1:0], out_end_offset[7:0]
//   config    psel/penable/pwrite    paddr[2:0], pwdata[31:0], prdata[31:0], pready
//
// One character is taken per cycle, sustained, when results are popped as they appear.
// When the item that ends the number is accepted, its token first enters the queue;
// the result register loads when the back end consumes it, which waits while a result is not popped.
// The back end's combinational multiply-add sets that rate of one character per cycle.
// Reset is synchronous; full rises when four tokens wait, while a result is not popped.
module string_to_unsigned_parser import stu_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [CHAR_W-1:0]      in_ch,
  input  logic                   in_first,
  output logic                   empty,
  input  logic                   pop,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic [CNT_W-1:0]       out_end_offset,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [BASE_W-1:0] number_base_r, number_base_nxt;
  logic              cfg_wr;
  logic              cfg_hit;
  logic              q_push, q_full, q_pop, q_empty;
  tok_t              q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_NUMBER_BASE);
  assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;

  assign number_base_nxt = cfg_wr ? pwdata[BASE_W-1:0] : number_base_r;
  assign prdata = cfg_hit ? CFG_DATA_W'(number_base_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_AUTO;
    end else begin
      number_base_r <= number_base_nxt;
    end
  end

  stu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_ch       (in_ch),
    .in_first    (in_first),
    .number_base (number_base_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  stu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_empty (q_empty)
  );

  stu_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_value      (out_value),
    .out_end_offset (out_end_offset)
  );

endmodule
